>>> src/fds_pkg.sv
package fds_pkg;

  // Fixed field widths
  localparam int DIST_W  = 48;
  localparam int SCORE_W = 15;
  localparam int OUT_W   = 64;
  localparam int SQ_IN_W = 24;  // magnitudes at or above 2^24 square past 48 bits
  localparam int QUO_W   = 14;  // every band quotient stays below 2^14
  localparam int CNT_W   = 4;
  localparam int MULT_W  = 14;
  localparam int NUM_W   = DIST_W + MULT_W;

  // Configuration register indexes
  localparam logic [1:0] REG_LEVEL_ONE    = 2'd0;
  localparam logic [1:0] REG_LEVEL_TWO    = 2'd1;
  localparam logic [1:0] REG_LEVEL_THREE  = 2'd2;
  localparam logic [1:0] REG_LEVELS_VALID = 2'd3;

  // Score constants, Q7.8 percent
  localparam logic [SCORE_W-1:0] SCORE_FULL = 15'd25600;
  localparam logic [SCORE_W-1:0] SCORE_KNEE = 15'd20480;
  localparam logic [SCORE_W-1:0] SCORE_ZERO = 15'd0;

  // Band slopes in Q7.8: score change when dx equals the band divisor
  localparam logic [MULT_W-1:0] SLOPE_UPPER  = 14'd7680;
  localparam logic [MULT_W-1:0] SLOPE_MIDDLE = 14'd5120;
  localparam logic [MULT_W-1:0] SLOPE_LOWER  = 14'd15360;

  // One third of level one, as 1000 * d < 333 * L1
  localparam logic [9:0] THIRD_DEN = 10'd1000;
  localparam logic [9:0] THIRD_NUM = 10'd333;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_THIRD,
    ST_SELECT,
    ST_SCALE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    BAND_ZERO,
    BAND_FULL,
    BAND_UPPER,
    BAND_MIDDLE,
    BAND_LOWER
  } band_t;

endpackage

>>> src/feature_distance_score_unit.sv
// Channel   Dir  Transfer                  Payload (lowest bit first)
// s_axis    in   tvalid & tready           tdata: elem_a, elem_b; tlast: last
// m_axis    out  tvalid & tready           tdata: score[14:0], distance[62:15]
// cfg       in   cfg_we at rising edge     cfg_index selects level/valid register
//
// Steps: an element pair without tlast passes difference, square and
// accumulate. A pair with tlast that needs a divide then goes on through
// band thresholds, selection, scaling, 14 iterations of the
// shared restoring divider and a finish step.
// A full or zero score skips scaling and divide.
// Reset: rst clears the sum, the configuration registers, the sequencer and m_axis_tvalid.
// Stalls: the result sits in an output register, so s_axis stays open while
// it waits; only the finish step of the next vector holds until it drains.
module feature_distance_score_unit #(
  parameter int ELEM_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // slave stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // elem_a [ELEM_BITS-1:0], elem_b [2*ELEM_BITS-1:ELEM_BITS], zero fill
  input  logic [((2*ELEM_BITS+7)/8)*8-1:0]     s_axis_tdata,
  input  logic                                 s_axis_tlast,
  // master stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // score [14:0], distance [62:15], zero at bit 63
  output logic [fds_pkg::OUT_W-1:0]            m_axis_tdata,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [fds_pkg::DIST_W-1:0]           cfg_data
);
  import fds_pkg::*;

  localparam int MAG_W = ELEM_BITS + 1;

  // Configuration registers
  logic [DIST_W-1:0] level_one;
  logic [DIST_W-1:0] level_two;
  logic [DIST_W-1:0] level_three;
  logic              levels_valid;

  // Sequencer
  state_t state;
  state_t state_next;

  // Datapath registers
  logic [MAG_W-1:0]       mag;
  logic                   last_r;
  logic [DIST_W-1:0]      sq;
  logic [DIST_W-1:0]      dist_sum;
  logic [DIST_W-1:0]      dist_total;
  logic [DIST_W+9:0]      d_scaled;
  logic [DIST_W+9:0]      l1_scaled;
  band_t                  band;
  logic [DIST_W-1:0]      dx;
  logic [DIST_W-1:0]      divisor;
  logic [NUM_W-1:0]       rem;
  logic [NUM_W-1:0]       div_sh;
  logic [QUO_W-1:0]       quo;
  logic [CNT_W-1:0]       cnt;
  logic [SCORE_W-1:0]     out_score;
  logic [DIST_W-1:0]      out_dist;

  // Combinational helpers
  logic signed [MAG_W-1:0] diff;
  logic [SQ_IN_W-1:0]      sq_in;
  logic [2*SQ_IN_W-1:0]    sq_prod;
  logic [DIST_W:0]         sum_ext;
  logic                    gt_l3;
  logic                    gt_l2;
  logic                    ge_l1;
  logic                    below_third;
  band_t                   band_sel;
  logic [DIST_W-1:0]       dx_sel;
  logic [DIST_W-1:0]       div_sel;
  logic [MULT_W-1:0]       slope;
  logic [NUM_W-1:0]        trial;
  logic                    trial_ok;
  logic [SCORE_W:0]        upper_sum;
  logic [SCORE_W-1:0]      ceil_q;
  logic [SCORE_W-1:0]      score_calc;
  logic                    out_free;
  logic                    out_load;
  logic                    in_xfer;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      level_one    <= '0;
      level_two    <= '0;
      level_three  <= '0;
      levels_valid <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEVEL_ONE:    level_one    <= cfg_data;
        REG_LEVEL_TWO:    level_two    <= cfg_data;
        REG_LEVEL_THREE:  level_three  <= cfg_data;
        REG_LEVELS_VALID: levels_valid <= cfg_data[0];
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Element difference, square and saturating sum
  // ---------------------------------------------------------------------
  assign diff = $signed({s_axis_tdata[ELEM_BITS-1], s_axis_tdata[ELEM_BITS-1:0]})
              - $signed({s_axis_tdata[2*ELEM_BITS-1], s_axis_tdata[2*ELEM_BITS-1:ELEM_BITS]});

  assign sq_in   = SQ_IN_W'(mag);
  assign sq_prod = (2*SQ_IN_W)'(sq_in) * (2*SQ_IN_W)'(sq_in);
  assign sum_ext = {1'b0, dist_sum} + {1'b0, sq};

  // ---------------------------------------------------------------------
  // Band selection. Tests are resolved from the last one that can hold,
  // so unordered levels fall through the same way as the ordered tests.
  // ---------------------------------------------------------------------
  assign gt_l3       = dist_total > level_three;
  assign gt_l2       = dist_total > level_two;
  assign ge_l1       = dist_total >= level_one;
  assign below_third = d_scaled < l1_scaled;

  always_comb begin
    band_sel = BAND_ZERO;
    dx_sel   = '0;
    div_sel  = '0;
    priority if (!levels_valid || gt_l3) begin
      band_sel = BAND_ZERO;
    end else if (gt_l2) begin
      band_sel = BAND_LOWER;
      dx_sel   = level_three - dist_total;
      div_sel  = level_three - level_two;
    end else if (ge_l1) begin
      // a flat middle band has no slope: score drops to zero
      band_sel = (level_two == level_one) ? BAND_ZERO : BAND_MIDDLE;
      dx_sel   = dist_total - level_one;
      div_sel  = level_two - level_one;
    end else if (below_third) begin
      band_sel = BAND_FULL;
    end else begin
      band_sel = BAND_UPPER;
      dx_sel   = level_one - dist_total;
      div_sel  = level_one;
    end
  end

  always_comb begin
    unique case (band)
      BAND_UPPER:  slope = SLOPE_UPPER;
      BAND_MIDDLE: slope = SLOPE_MIDDLE;
      BAND_LOWER:  slope = SLOPE_LOWER;
      default:     slope = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Shared restoring divider: one quotient bit per cycle
  // ---------------------------------------------------------------------
  assign trial    = rem - div_sh;
  assign trial_ok = rem >= div_sh;

  // ---------------------------------------------------------------------
  // Final score from quotient and remainder
  // ---------------------------------------------------------------------
  assign upper_sum = {1'b0, SCORE_KNEE} + (SCORE_W + 1)'(quo);
  assign ceil_q    = SCORE_W'(quo) + SCORE_W'(rem != '0);

  always_comb begin
    unique case (band)
      BAND_FULL:   score_calc = SCORE_FULL;
      // the upper band can overshoot 100 by a hair next to one third of L1
      BAND_UPPER:  score_calc = (upper_sum > {1'b0, SCORE_FULL}) ? SCORE_FULL
                                                                 : upper_sum[SCORE_W-1:0];
      BAND_MIDDLE: score_calc = SCORE_KNEE - ceil_q;
      BAND_LOWER:  score_calc = SCORE_W'(quo);
      default:     score_calc = SCORE_ZERO;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_axis_tvalid) state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_ACCUM;
      ST_ACCUM:  state_next = last_r ? ST_THIRD : ST_IDLE;
      ST_THIRD:  state_next = ST_SELECT;
      ST_SELECT: begin
        if (band_sel == BAND_UPPER || band_sel == BAND_MIDDLE || band_sel == BAND_LOWER) begin
          state_next = ST_SCALE;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SCALE:  state_next = ST_DIVIDE;
      ST_DIVIDE: if (cnt == '0) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    out_free      = !m_axis_tvalid || m_axis_tready;
    out_load      = (state == ST_FINISH) && out_free;
    in_xfer       = s_axis_tvalid && s_axis_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Running sum: clear after the last pair of a vector
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_sum <= '0;
    end else if (state == ST_ACCUM) begin
      if (last_r) begin
        dist_sum <= '0;
      end else begin
        dist_sum <= sum_ext[DIST_W] ? '1 : sum_ext[DIST_W-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mag    <= diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
      last_r <= s_axis_tlast;
    end
    if (state == ST_SQUARE) begin
      sq <= (|(mag >> SQ_IN_W)) ? '1 : DIST_W'(sq_prod);
    end
    if (state == ST_ACCUM) begin
      dist_total <= sum_ext[DIST_W] ? '1 : sum_ext[DIST_W-1:0];
    end
    if (state == ST_THIRD) begin
      d_scaled  <= (DIST_W+10)'(dist_total) * (DIST_W+10)'(THIRD_DEN);
      l1_scaled <= (DIST_W+10)'(level_one) * (DIST_W+10)'(THIRD_NUM);
    end
    if (state == ST_SELECT) begin
      band    <= band_sel;
      dx      <= dx_sel;
      divisor <= div_sel;
    end
    if (state == ST_SCALE) begin
      rem    <= NUM_W'(dx) * NUM_W'(slope);
      div_sh <= NUM_W'(divisor) << (QUO_W - 1);
      quo    <= '0;
      cnt    <= CNT_W'(QUO_W - 1);
    end
    if (state == ST_DIVIDE) begin
      // take one quotient bit, then move the divisor down one place
      if (trial_ok) begin
        rem <= trial;
      end
      quo    <= {quo[QUO_W-2:0], trial_ok};
      div_sh <= div_sh >> 1;
      cnt    <= cnt - CNT_W'(1);
    end
    if (out_load) begin
      out_score <= score_calc;
      out_dist  <= dist_total;
    end
  end

  // Output register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {1'b0, out_dist, out_score};

`ifndef SYNTHESIS
  a_result_from_finish : assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_FINISH))
    else $error("result raised outside the finish step");

  a_sum_cleared : assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACCUM && last_r) |=> (dist_sum == '0))
    else $error("distance sum not cleared after last pair");

  a_divide_done : assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && (band == BAND_UPPER || band == BAND_MIDDLE ||
                            band == BAND_LOWER)) |-> (rem < NUM_W'(divisor)))
    else $error("divider remainder not below divisor");

  a_score_range : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[SCORE_W-1:0] <= SCORE_FULL))
    else $error("score above 100 percent");
`endif

endmodule
